>>> sv/mac_pkg.sv
// shared types, widths and constants of the masked alpha compositing pipeline
`default_nettype none

package mac_pkg;

  // fixed field widths
  localparam int CH_W  = 20;
  localparam int OP_W  = 2;
  localparam int MSK_W = 16;
  localparam int ADD_W = 8;
  localparam int NCH   = 4;
  localparam int CH_ALPHA = 3;

  // fixed point format and coverage mask size
  localparam int FRAC_BITS = 16;
  localparam int MASK_BITS = 16;

  // derived arithmetic widths
  localparam int CNT_W  = $clog2(MASK_BITS + 1);
  localparam int D_W    = 8;
  localparam int K_W    = 8;
  localparam int KA_W   = K_W + CH_W;
  localparam int W_W    = ((D_W + FRAC_BITS > KA_W) ? D_W + FRAC_BITS : KA_W) + 1;
  localparam int P_W    = W_W + CH_W + 1;
  localparam int DY_W   = D_W + CH_W;
  localparam int NUM_W  = ((P_W > DY_W + FRAC_BITS + 1) ? P_W : DY_W + FRAC_BITS + 1) + 1;
  localparam int X_W    = D_W + CH_W;
  localparam int RK     = X_W;
  localparam int M_W    = RK + 1;
  localparam int PROD_W = X_W + M_W;

  localparam longint unsigned RECIP_NUM = 64'd1 << RK;

  localparam logic [CH_W-1:0]  CH_MAX   = '1;
  localparam logic [MSK_W-1:0] MASK_SEL = MSK_W'((64'd1 << MASK_BITS) - 64'd1);
  localparam logic [CH_W-1:0]  ALPHA_FULL =
    CH_W'((64'd9998 * (64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [D_W-1:0]   FACTOR_DEN = 8'd255;
  localparam logic [K_W-1:0]   ADD_FULL   = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_OVER   = 2'd0,
    OP_UNDER  = 2'd1,
    OP_FACTOR = 2'd2,
    OP_MASK   = 2'd3
  } op_t;

  typedef logic [NCH-1:0][CH_W-1:0] pix_t;

  // blend set-up: weight = den*one - ka, result = (weight*xop + den*one*yop) / (den*one)
  typedef struct packed {
    pix_t            xop;
    pix_t            yop;
    logic [KA_W-1:0] ka;
    logic [D_W-1:0]  den;
    logic            clip;
  } setup_t;

  typedef struct packed {
    logic [NCH-1:0][NUM_W-1:0] num;
    logic [D_W-1:0]            den;
    logic                      clip;
  } sum_t;

  // floor(2^RK / den) for the denominators that can occur
  function automatic logic [M_W-1:0] recip(input logic [D_W-1:0] den);
    logic [M_W-1:0] m;
    unique case (den)
      8'd1:    m = M_W'(RECIP_NUM);
      8'd2:    m = M_W'(RECIP_NUM / 2);
      8'd3:    m = M_W'(RECIP_NUM / 3);
      8'd4:    m = M_W'(RECIP_NUM / 4);
      8'd5:    m = M_W'(RECIP_NUM / 5);
      8'd6:    m = M_W'(RECIP_NUM / 6);
      8'd7:    m = M_W'(RECIP_NUM / 7);
      8'd8:    m = M_W'(RECIP_NUM / 8);
      8'd9:    m = M_W'(RECIP_NUM / 9);
      8'd10:   m = M_W'(RECIP_NUM / 10);
      8'd11:   m = M_W'(RECIP_NUM / 11);
      8'd12:   m = M_W'(RECIP_NUM / 12);
      8'd13:   m = M_W'(RECIP_NUM / 13);
      8'd14:   m = M_W'(RECIP_NUM / 14);
      8'd15:   m = M_W'(RECIP_NUM / 15);
      8'd16:   m = M_W'(RECIP_NUM / 16);
      8'd255:  m = M_W'(RECIP_NUM / 255);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> sv/mac_setup.sv
// first stage: opcode decode, mask popcounts and the alpha scaling product
`default_nettype none

module mac_setup (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mac_pkg::OP_W-1:0]    in_opcode,
  input  wire mac_pkg::pix_t               in_dest,
  input  wire mac_pkg::pix_t               in_src,
  input  wire logic [mac_pkg::MSK_W-1:0]   in_dest_mask,
  input  wire logic [mac_pkg::MSK_W-1:0]   in_src_mask,
  input  wire logic [mac_pkg::ADD_W-1:0]   in_add_factor,
  output logic                             st_valid,
  input  wire logic                        st_ready,
  output mac_pkg::setup_t                  st_data
);

  logic [mac_pkg::MSK_W-1:0] dm, sm, sh;
  logic [mac_pkg::CNT_W-1:0] nsh, tot;
  logic                      partial, disjoint;
  logic [mac_pkg::D_W-1:0]   den;
  logic [mac_pkg::K_W-1:0]   kf;
  logic [mac_pkg::CH_W-1:0]  alpha;
  mac_pkg::pix_t             xop, yop;
  logic                      en;
  logic                      v_r;
  mac_pkg::setup_t           st_r, st_nxt;

  always_comb begin
    dm       = in_dest_mask & mac_pkg::MASK_SEL;
    sm       = in_src_mask & mac_pkg::MASK_SEL;
    sh       = dm & sm;
    nsh      = mac_pkg::CNT_W'($countones(sh));
    tot      = mac_pkg::CNT_W'($countones(dm | sm));
    partial  = (sh != '0) && (sh != dm);
    disjoint = (sh == '0) && (dm != '0) && (sm != '0);
    den      = mac_pkg::D_W'(1);
    kf       = mac_pkg::K_W'(1);
    alpha    = in_src[mac_pkg::CH_ALPHA];
    xop      = in_dest;
    yop      = in_src;
    unique case (mac_pkg::op_t'(in_opcode))
      mac_pkg::OP_OVER: begin
        den = mac_pkg::D_W'(1);
      end
      mac_pkg::OP_UNDER: begin
        alpha = in_dest[mac_pkg::CH_ALPHA];
        xop   = in_src;
        yop   = in_dest;
      end
      mac_pkg::OP_FACTOR: begin
        den = mac_pkg::FACTOR_DEN;
        kf  = mac_pkg::ADD_FULL - in_add_factor;
      end
      mac_pkg::OP_MASK: begin
        if (partial) begin
          den = mac_pkg::D_W'(tot);
          kf  = mac_pkg::K_W'(nsh);
        end else if (disjoint) begin
          // pure add: weight one, denominator one
          kf = '0;
        end
      end
      default: begin
        den = mac_pkg::D_W'(1);
      end
    endcase
    st_nxt.xop  = xop;
    st_nxt.yop  = yop;
    st_nxt.ka   = mac_pkg::KA_W'(kf) * mac_pkg::KA_W'(alpha);
    st_nxt.den  = den;
    st_nxt.clip = (mac_pkg::op_t'(in_opcode) == mac_pkg::OP_FACTOR);
  end

  assign en       = !v_r || st_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      st_r <= st_nxt;
    end
  end

  assign st_valid = v_r;
  assign st_data  = st_r;

endmodule

`default_nettype wire

>>> sv/mac_blend.sv
// stages two and three: weight, per-channel products and the blend numerator
`default_nettype none

module mac_blend (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          st_valid,
  output logic               st_ready,
  input  wire mac_pkg::setup_t st_data,
  output logic               sum_valid,
  input  wire logic          sum_ready,
  output mac_pkg::sum_t      sum_data
);

  logic [mac_pkg::W_W-1:0]        dsh, kae;
  logic signed [mac_pkg::W_W-1:0] w;
  logic signed [mac_pkg::P_W-1:0] p_nxt [mac_pkg::NCH];
  logic [mac_pkg::DY_W-1:0]       dy_nxt [mac_pkg::NCH];
  logic signed [mac_pkg::P_W-1:0] p_r [mac_pkg::NCH];
  logic [mac_pkg::DY_W-1:0]       dy_r [mac_pkg::NCH];
  logic [mac_pkg::D_W-1:0]        den2_r;
  logic                           clip2_r;
  logic signed [mac_pkg::NUM_W-1:0] sum [mac_pkg::NCH];
  mac_pkg::sum_t                  sum_r, sum_nxt;
  logic                           v2_r, v3_r, en2, en3;

  // stage two: weight and the two products per channel
  always_comb begin
    dsh = mac_pkg::W_W'(st_data.den) << mac_pkg::FRAC_BITS;
    kae = mac_pkg::W_W'(st_data.ka);
    w   = $signed(dsh) - $signed(kae);
    for (int i = 0; i < mac_pkg::NCH; i++) begin
      p_nxt[i]  = w * $signed({1'b0, st_data.xop[i]});
      dy_nxt[i] = mac_pkg::DY_W'(st_data.den) * mac_pkg::DY_W'(st_data.yop[i]);
    end
  end

  // stage three: numerator
  always_comb begin
    for (int i = 0; i < mac_pkg::NCH; i++) begin
      sum[i] = mac_pkg::NUM_W'(p_r[i])
             + $signed(mac_pkg::NUM_W'({dy_r[i], {mac_pkg::FRAC_BITS{1'b0}}}));
      sum_nxt.num[i] = sum[i];
    end
    sum_nxt.den  = den2_r;
    sum_nxt.clip = clip2_r;
  end

  assign en3      = !v3_r || sum_ready;
  assign en2      = !v2_r || en3;
  assign st_ready = en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en2) begin
        v2_r <= st_valid;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && st_valid) begin
      p_r     <= p_nxt;
      dy_r    <= dy_nxt;
      den2_r  <= st_data.den;
      clip2_r <= st_data.clip;
    end
    if (en3 && v2_r) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_valid = v3_r;
  assign sum_data  = sum_r;

endmodule

`default_nettype wire

>>> sv/mac_div.sv
// stages four to six: rounding, reciprocal divide, saturation and alpha clip
`default_nettype none

module mac_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          sum_valid,
  output logic               sum_ready,
  input  wire mac_pkg::sum_t sum_data,
  output logic               pix_valid,
  input  wire logic          pix_ready,
  output mac_pkg::pix_t      pix_data
);

  localparam int XF_W = mac_pkg::NUM_W - mac_pkg::FRAC_BITS;

  logic signed [mac_pkg::NUM_W-1:0] num [mac_pkg::NCH];
  logic signed [mac_pkg::NUM_W-1:0] numr [mac_pkg::NCH];
  logic [mac_pkg::NUM_W-1:0]        rnd;
  logic [XF_W-1:0]                  xf [mac_pkg::NCH];
  logic [XF_W-1:0]                  lim;
  logic                             pos [mac_pkg::NCH];
  logic [mac_pkg::X_W-1:0]          x_nxt [mac_pkg::NCH];
  logic                             sat_nxt [mac_pkg::NCH];

  logic [mac_pkg::X_W-1:0]  x4_r [mac_pkg::NCH];
  logic                     sat4_r [mac_pkg::NCH];
  logic [mac_pkg::M_W-1:0]  m4_r;
  logic [mac_pkg::D_W-1:0]  den4_r;
  logic                     clip4_r;

  logic [mac_pkg::PROD_W-1:0] prod [mac_pkg::NCH];
  logic [mac_pkg::CH_W-1:0]   q_nxt [mac_pkg::NCH];
  logic [mac_pkg::CH_W-1:0]   q5_r [mac_pkg::NCH];
  logic [mac_pkg::X_W-1:0]    x5_r [mac_pkg::NCH];
  logic                       sat5_r [mac_pkg::NCH];
  logic [mac_pkg::D_W-1:0]    den5_r;
  logic                       clip5_r;

  logic [mac_pkg::X_W-1:0]  qd [mac_pkg::NCH];
  logic [mac_pkg::X_W-1:0]  rem [mac_pkg::NCH];
  mac_pkg::pix_t            pix_r, pix_nxt;

  logic v4_r, v5_r, v6_r, en4, en5, en6;

  // stage four: round to nearest, overflow check, reciprocal lookup
  always_comb begin
    rnd = mac_pkg::NUM_W'({sum_data.den, {(mac_pkg::FRAC_BITS - 1){1'b0}}});
    lim = XF_W'({sum_data.den, {mac_pkg::CH_W{1'b0}}});
    for (int i = 0; i < mac_pkg::NCH; i++) begin
      num[i]     = $signed(sum_data.num[i]);
      pos[i]     = !num[i][mac_pkg::NUM_W-1] && (num[i] != '0);
      numr[i]    = num[i] + $signed(rnd);
      xf[i]      = numr[i][mac_pkg::NUM_W-1:mac_pkg::FRAC_BITS];
      sat_nxt[i] = pos[i] && (xf[i] >= lim);
      x_nxt[i]   = pos[i] ? mac_pkg::X_W'(xf[i]) : '0;
    end
  end

  // stage five: quotient estimate, low by at most one
  always_comb begin
    for (int i = 0; i < mac_pkg::NCH; i++) begin
      prod[i]  = mac_pkg::PROD_W'(x4_r[i]) * mac_pkg::PROD_W'(m4_r);
      q_nxt[i] = prod[i][mac_pkg::RK +: mac_pkg::CH_W];
    end
  end

  // stage six: correct, saturate, clip alpha in factor mode
  always_comb begin
    for (int i = 0; i < mac_pkg::NCH; i++) begin
      qd[i]  = mac_pkg::X_W'(q5_r[i]) * mac_pkg::X_W'(den5_r);
      rem[i] = x5_r[i] - qd[i];
      if (sat5_r[i]) begin
        pix_nxt[i] = mac_pkg::CH_MAX;
      end else if (rem[i] >= mac_pkg::X_W'(den5_r)) begin
        pix_nxt[i] = q5_r[i] + mac_pkg::CH_W'(1);
      end else begin
        pix_nxt[i] = q5_r[i];
      end
    end
    if (clip5_r && (pix_nxt[mac_pkg::CH_ALPHA] >= mac_pkg::ALPHA_FULL)) begin
      pix_nxt[mac_pkg::CH_ALPHA] = mac_pkg::ALPHA_FULL;
    end
  end

  assign en6       = !v6_r || pix_ready;
  assign en5       = !v5_r || en6;
  assign en4       = !v4_r || en5;
  assign sum_ready = en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en4) begin
        v4_r <= sum_valid;
      end
      if (en5) begin
        v5_r <= v4_r;
      end
      if (en6) begin
        v6_r <= v5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && sum_valid) begin
      x4_r    <= x_nxt;
      sat4_r  <= sat_nxt;
      m4_r    <= mac_pkg::recip(sum_data.den);
      den4_r  <= sum_data.den;
      clip4_r <= sum_data.clip;
    end
    if (en5 && v4_r) begin
      q5_r    <= q_nxt;
      x5_r    <= x4_r;
      sat5_r  <= sat4_r;
      den5_r  <= den4_r;
      clip5_r <= clip4_r;
    end
    if (en6 && v5_r) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix_valid = v6_r;
  assign pix_data  = pix_r;

endmodule

`default_nettype wire

>>> sv/masked_alpha_compositing_top.sv
// top level of the premultiplied rgba compositing pipeline
//
// usage: one request on the in_ channel carries a destination pixel, a
// premultiplied source pixel, two coverage masks, an additive factor and an
// opcode (over, under, factor blend, coverage-mask over). every request gives
// exactly one blended pixel on the out_ channel, in order. both channels use
// valid/ready; a request moves on a clock edge where valid and ready are high.
// pipeline: six register stages (setup, products, numerator, rounding,
// reciprocal multiply, correction/saturation); out_valid is the valid bit
// of the last stage, whose register drives the out_ ports.
// throughput: one request per clock; each stage holds its own valid bit and
// only waits when the stage ahead is full and stalled.
// the divide by the blend denominator is a multiply by a table reciprocal
// followed by a single correction step, so no stage iterates.
// reset: rst_n low clears every valid bit; the pipeline comes out empty and
// in_ready high. payload registers are not reset.
// stall: with out_ready low the result holds on the out_ ports; bubbles
// further back still close up, so in_ready stays high until all six
// stages hold requests.
`default_nettype none

module masked_alpha_compositing_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [19:0] in_dest_red,
  input  wire logic [19:0] in_dest_green,
  input  wire logic [19:0] in_dest_blue,
  input  wire logic [19:0] in_dest_alpha,
  input  wire logic [19:0] in_src_red,
  input  wire logic [19:0] in_src_green,
  input  wire logic [19:0] in_src_blue,
  input  wire logic [19:0] in_src_alpha,
  input  wire logic [15:0] in_dest_mask,
  input  wire logic [15:0] in_src_mask,
  input  wire logic [7:0]  in_add_factor,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [19:0]      out_red,
  output logic [19:0]      out_green,
  output logic [19:0]      out_blue,
  output logic [19:0]      out_alpha
);

  // channel order inside a pixel: red, green, blue, alpha
  mac_pkg::pix_t   dest_pix, src_pix, res_pix;
  mac_pkg::setup_t st_data;
  mac_pkg::sum_t   sum_data;
  logic            st_valid, st_ready;
  logic            sum_valid, sum_ready;

  assign dest_pix[0] = in_dest_red;
  assign dest_pix[1] = in_dest_green;
  assign dest_pix[2] = in_dest_blue;
  assign dest_pix[3] = in_dest_alpha;
  assign src_pix[0]  = in_src_red;
  assign src_pix[1]  = in_src_green;
  assign src_pix[2]  = in_src_blue;
  assign src_pix[3]  = in_src_alpha;

  // stage one: mode decode, popcounts, alpha scaling
  mac_setup u_setup (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_dest       (dest_pix),
    .in_src        (src_pix),
    .in_dest_mask  (in_dest_mask),
    .in_src_mask   (in_src_mask),
    .in_add_factor (in_add_factor),
    .st_valid      (st_valid),
    .st_ready      (st_ready),
    .st_data       (st_data)
  );

  // stages two and three: weighted products and numerator
  mac_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_valid  (st_valid),
    .st_ready  (st_ready),
    .st_data   (st_data),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data)
  );

  // stages four to six: round, divide, saturate; stage six is the output register
  mac_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data),
    .pix_valid (out_valid),
    .pix_ready (out_ready),
    .pix_data  (res_pix)
  );

  assign out_red   = res_pix[0];
  assign out_green = res_pix[1];
  assign out_blue  = res_pix[2];
  assign out_alpha = res_pix[3];

  // reset leaves the pipeline empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // an empty output stage never holds back new requests
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage empty");

  // with the receiver taking results, an accepted request's result reaches out_valid after passing every stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

`default_nettype wire

>>> test/masked_alpha_compositing_checker.sv
// checker for the compositing pipeline: predicts each blended pixel and compares the out_ channel
`timescale 1ns / 1ps

module masked_alpha_compositing_checker
  import mac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [OP_W-1:0]  in_opcode,
  input  logic [CH_W-1:0]  in_dest_red,
  input  logic [CH_W-1:0]  in_dest_green,
  input  logic [CH_W-1:0]  in_dest_blue,
  input  logic [CH_W-1:0]  in_dest_alpha,
  input  logic [CH_W-1:0]  in_src_red,
  input  logic [CH_W-1:0]  in_src_green,
  input  logic [CH_W-1:0]  in_src_blue,
  input  logic [CH_W-1:0]  in_src_alpha,
  input  logic [MSK_W-1:0] in_dest_mask,
  input  logic [MSK_W-1:0] in_src_mask,
  input  logic [ADD_W-1:0] in_add_factor,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [CH_W-1:0]  out_red,
  input  logic [CH_W-1:0]  out_green,
  input  logic [CH_W-1:0]  out_blue,
  input  logic [CH_W-1:0]  out_alpha,
  output int               fail_count,
  output int               pending_count
);

  localparam longint PIX_ONE    = longint'(1) << FRAC_BITS;
  localparam longint PIX_MAX    = (longint'(1) << CH_W) - 1;
  localparam longint ALPHA_CLIP = (9998 * PIX_ONE + 5000) / 10000;
  localparam logic [MSK_W-1:0] COVER_BITS = MSK_W'((longint'(1) << MASK_BITS) - 1);

  pix_t expected_px_q[$];
  int   fails   = 0;
  int   pending = 0;

  assign fail_count    = fails;
  assign pending_count = pending;

  // round((w*x + den*one*y) / (den*one)), clamped to the channel range
  function automatic logic [CH_W-1:0] weighted_round(longint w, longint den,
                                                     longint x, longint y);
    longint d;
    longint num;
    longint q;
    d   = den * PIX_ONE;
    num = w * x + d * y;
    if (num <= 0) return '0;
    q = (num + d / 2) / d;
    if (q > PIX_MAX) q = PIX_MAX;
    return q[CH_W-1:0];
  endfunction

  function automatic pix_t composite(op_t op, pix_t dst, pix_t src,
                                     logic [MSK_W-1:0] dmask, logic [MSK_W-1:0] smask,
                                     logic [ADD_W-1:0] add_f);
    pix_t             res;
    longint           w;
    longint           den;
    longint           sa;
    longint           sum;
    logic [MSK_W-1:0] dm;
    logic [MSK_W-1:0] sm;
    logic [MSK_W-1:0] shared;
    int               nsh;
    int               tot;
    bit               additive;
    sa       = longint'(src[CH_ALPHA]);
    w        = PIX_ONE - sa;
    den      = 1;
    additive = 1'b0;
    dm       = dmask & COVER_BITS;
    sm       = smask & COVER_BITS;
    shared   = dm & sm;
    if (op == OP_UNDER) begin
      for (int i = 0; i < NCH; i++)
        res[i] = weighted_round(PIX_ONE - longint'(dst[CH_ALPHA]), 1, src[i], dst[i]);
      return res;
    end
    case (op)
      OP_FACTOR: begin
        w   = 255 * PIX_ONE - sa * (255 - longint'(add_f));
        den = 255;
      end
      OP_MASK: begin
        if (shared != '0 && shared != dm) begin
          // partial overlap: unshared samples add, shared ones go over
          nsh = $countones(shared);
          tot = $countones(dm | sm);
          w   = longint'(tot - nsh) * PIX_ONE + longint'(nsh) * (PIX_ONE - sa);
          den = tot;
        end else if (shared == '0 && dm != '0 && sm != '0) begin
          additive = 1'b1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NCH; i++) begin
      if (additive) begin
        sum    = longint'(dst[i]) + longint'(src[i]);
        res[i] = (sum > PIX_MAX) ? CH_W'(PIX_MAX) : sum[CH_W-1:0];
      end else begin
        res[i] = weighted_round(w, den, dst[i], src[i]);
      end
    end
    if (op == OP_FACTOR && longint'(res[CH_ALPHA]) >= ALPHA_CLIP)
      res[CH_ALPHA] = CH_W'(ALPHA_CLIP);
    return res;
  endfunction

  function automatic string chan_name(int i);
    case (i)
      0:       return "out_red";
      1:       return "out_green";
      2:       return "out_blue";
      default: return "out_alpha";
    endcase
  endfunction

  always @(posedge clk) begin
    pix_t want;
    pix_t got;
    got = {out_alpha, out_blue, out_green, out_red};
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_px_q.push_back(composite(op_t'(in_opcode),
          {in_dest_alpha, in_dest_blue, in_dest_green, in_dest_red},
          {in_src_alpha, in_src_blue, in_src_green, in_src_red},
          in_dest_mask, in_src_mask, in_add_factor));
      if (out_valid && out_ready) begin
        if (expected_px_q.size() == 0) begin
          $error("out_ request with no pixel expected");
          fails++;
        end else begin
          want = expected_px_q.pop_front();
          for (int i = 0; i < NCH; i++) begin
            if (got[i] !== want[i]) begin
              $error("%s: expected %0d, actual %0d", chan_name(i), want[i], got[i]);
              fails++;
            end
          end
        end
      end
      pending = expected_px_q.size();
    end
  end

endmodule

>>> test/tb_masked_alpha_compositing_top.sv
// testbench top: drives requests into the compositing pipeline and gives the verdict
`timescale 1ns / 1ps

module tb_masked_alpha_compositing_top;
  import mac_pkg::*;

  localparam int RESET_CYCLES  = 9;
  localparam int HOLDOFF_LEN   = 80;     // receiver hold-off, well past the six stages
  localparam int DRAIN_CYCLES  = 20;     // idle wait once no predicted pixel is pending
  localparam int WATCHDOG_LIM  = 2000;   // cycles with no request moving on either side
  localparam int PHASE_ITEMS   = 220;

  localparam logic [CH_W-1:0] FX_ONE  = CH_W'(1 << FRAC_BITS);
  localparam logic [CH_W-1:0] FX_HALF = CH_W'(1 << (FRAC_BITS - 1));
  localparam logic [CH_W-1:0] FX_TOP  = '1;
  // alpha just under the factor-blend clip level (0.9998 on the grid is 65523)
  localparam logic [CH_W-1:0] FX_NEAR_CLIP = CH_W'(65522);

  typedef struct packed {
    op_t              op;
    pix_t             dst;
    pix_t             src;
    logic [MSK_W-1:0] dm;
    logic [MSK_W-1:0] sm;
    logic [ADD_W-1:0] af;
  } pixel_req_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  in_opcode;
  logic [CH_W-1:0]  in_dest_red;
  logic [CH_W-1:0]  in_dest_green;
  logic [CH_W-1:0]  in_dest_blue;
  logic [CH_W-1:0]  in_dest_alpha;
  logic [CH_W-1:0]  in_src_red;
  logic [CH_W-1:0]  in_src_green;
  logic [CH_W-1:0]  in_src_blue;
  logic [CH_W-1:0]  in_src_alpha;
  logic [MSK_W-1:0] in_dest_mask;
  logic [MSK_W-1:0] in_src_mask;
  logic [ADD_W-1:0] in_add_factor;
  logic             out_valid;
  logic             out_ready;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic [CH_W-1:0]  out_alpha;

  int fail_count;
  int pending_count;

  // idling knobs, percent of cycles; changed per phase by the stimulus
  int tx_idle_pct;
  int rx_stall_pct;
  bit holdoff_go;
  int idle_run;

  masked_alpha_compositing_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_dest_red   (in_dest_red),
    .in_dest_green (in_dest_green),
    .in_dest_blue  (in_dest_blue),
    .in_dest_alpha (in_dest_alpha),
    .in_src_red    (in_src_red),
    .in_src_green  (in_src_green),
    .in_src_blue   (in_src_blue),
    .in_src_alpha  (in_src_alpha),
    .in_dest_mask  (in_dest_mask),
    .in_src_mask   (in_src_mask),
    .in_add_factor (in_add_factor),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha)
  );

  // the checker sees both channels and keeps its own queue of predicted pixels
  masked_alpha_compositing_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_dest_red   (in_dest_red),
    .in_dest_green (in_dest_green),
    .in_dest_blue  (in_dest_blue),
    .in_dest_alpha (in_dest_alpha),
    .in_src_red    (in_src_red),
    .in_src_green  (in_src_green),
    .in_src_blue   (in_src_blue),
    .in_src_alpha  (in_src_alpha),
    .in_dest_mask  (in_dest_mask),
    .in_src_mask   (in_src_mask),
    .in_add_factor (in_add_factor),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // channel order inside pix_t is red at index 0 up to alpha at index 3
  function automatic pix_t px(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                              logic [CH_W-1:0] b, logic [CH_W-1:0] a);
    return {a, b, g, r};
  endfunction

  function automatic pixel_req_t mk_req(op_t op, pix_t dst, pix_t src,
                                        logic [MSK_W-1:0] dm, logic [MSK_W-1:0] sm,
                                        logic [ADD_W-1:0] af);
    pixel_req_t r;
    r.op  = op;
    r.dst = dst;
    r.src = src;
    r.dm  = dm;
    r.sm  = sm;
    r.af  = af;
    return r;
  endfunction

  function automatic logic [CH_W-1:0] corner_channel();
    case ($urandom_range(3))
      0:       return '0;
      1:       return FX_ONE;
      2:       return FX_ONE - 1'b1;
      default: return FX_TOP;
    endcase
  endfunction

  // mostly well-formed premultiplied pixels (colour at or below alpha,
  // alpha within one or a corner value), the rest raw 20-bit noise to hit saturation
  function automatic pix_t rand_pixel();
    pix_t            p;
    logic [CH_W-1:0] a;
    if ($urandom_range(99) < 80) begin
      a = ($urandom_range(9) == 0) ? corner_channel() : CH_W'($urandom_range(FX_ONE, 0));
      p[CH_ALPHA] = a;
      for (int i = 0; i < CH_ALPHA; i++)
        p[i] = CH_W'($urandom_range(a, 0));
    end else begin
      for (int i = 0; i < NCH; i++)
        p[i] = ($urandom_range(3) == 0) ? corner_channel() : CH_W'($urandom);
    end
    return p;
  endfunction

  function automatic pixel_req_t rand_req();
    pixel_req_t r;
    r.op  = op_t'($urandom_range(3));
    r.dst = rand_pixel();
    r.src = rand_pixel();
    r.dm  = MSK_W'($urandom);
    // mask shapes: free, disjoint, source covering dest, partial overlap, extremes
    case ($urandom_range(4))
      0:       r.sm = MSK_W'($urandom);
      1:       r.sm = MSK_W'($urandom) & ~r.dm;
      2:       r.sm = r.dm | MSK_W'($urandom);
      3:       r.sm = (r.dm & MSK_W'($urandom)) | (MSK_W'($urandom) & ~r.dm);
      default: begin
        r.dm = $urandom_range(1) ? '1 : '0;
        r.sm = $urandom_range(1) ? '1 : '0;
      end
    endcase
    case ($urandom_range(3))
      0:       r.af = ADD_W'($urandom_range(1) ? 0 : 255);
      1:       r.af = ADD_W'($urandom_range(1) ? 1 : 254);
      default: r.af = ADD_W'($urandom);
    endcase
    return r;
  endfunction

  // offer one request, with random idle cycles ahead of it, and hold it
  // until the pipeline takes it
  task automatic send_req(input pixel_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= r.op;
    in_dest_red   <= r.dst[0];
    in_dest_green <= r.dst[1];
    in_dest_blue  <= r.dst[2];
    in_dest_alpha <= r.dst[CH_ALPHA];
    in_src_red    <= r.src[0];
    in_src_green  <= r.src[1];
    in_src_blue   <= r.src[2];
    in_src_alpha  <= r.src[CH_ALPHA];
    in_dest_mask  <= r.dm;
    in_src_mask   <= r.sm;
    in_add_factor <= r.af;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int n = 0; n < count; n++)
      send_req(rand_req());
  endtask

  // receiver: random stalls, plus one long hold-off counted here so the
  // pipeline fills and in_ready drops while requests keep coming
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_go) begin
        out_ready  <= 1'b0;
        holdoff_go  = 1'b0;
        for (n = 0; n < HOLDOFF_LEN; n++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog: too long with no request moving on either channel
  initial begin
    idle_run = 0;
    while (idle_run < WATCHDOG_LIM) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("masked_alpha_compositing_top regression: fail");
    $finish;
  end

  // stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = '0;
    in_dest_red   = '0;
    in_dest_green = '0;
    in_dest_blue  = '0;
    in_dest_alpha = '0;
    in_src_red    = '0;
    in_src_green  = '0;
    in_src_blue   = '0;
    in_src_alpha  = '0;
    in_dest_mask  = '0;
    in_src_mask   = '0;
    in_add_factor = '0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    holdoff_go    = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // over: empty, all-max (alpha above one, weight negative), opaque, half
    send_req(mk_req(OP_OVER, px(0, 0, 0, 0), px(0, 0, 0, 0), '0, '0, '0));
    send_req(mk_req(OP_OVER, px(FX_TOP, FX_TOP, FX_TOP, FX_TOP),
                    px(FX_TOP, FX_TOP, FX_TOP, FX_TOP), '1, '1, '1));
    send_req(mk_req(OP_OVER, px(FX_ONE, FX_HALF, 20'd1, FX_ONE),
                    px(FX_HALF, 20'd3, FX_ONE, FX_ONE), 16'h00ff, 16'hff00, 8'd7));
    send_req(mk_req(OP_OVER, px(20'd40000, 20'd12345, FX_HALF, FX_ONE),
                    px(20'd1000, FX_HALF, 20'd7, FX_HALF), '0, '0, '0));
    // under: transparent dest, opaque dest, dest alpha above one, overflow
    send_req(mk_req(OP_UNDER, px(20'd5, 20'd6, 20'd7, 20'd0),
                    px(FX_HALF, FX_ONE, 20'd100, FX_ONE), '0, '0, '0));
    send_req(mk_req(OP_UNDER, px(FX_HALF, 20'd9, 20'd77, FX_ONE),
                    px(FX_ONE, FX_ONE, FX_ONE, FX_ONE), '1, '0, '1));
    send_req(mk_req(OP_UNDER, px(FX_ONE, 20'd3, FX_HALF, FX_TOP),
                    px(FX_HALF, FX_ONE, FX_ONE, FX_ONE), '0, '1, '0));
    send_req(mk_req(OP_UNDER, px(FX_TOP, FX_TOP, FX_TOP, 20'd0),
                    px(FX_TOP, FX_ONE, FX_TOP, FX_TOP), '0, '0, '0));
    // factor blend: plain over, fully additive with overflow, alpha clip
    send_req(mk_req(OP_FACTOR, px(20'd30000, 20'd20000, 20'd10000, FX_ONE),
                    px(20'd5000, 20'd6000, 20'd7000, FX_HALF), '0, '0, 8'd0));
    send_req(mk_req(OP_FACTOR, px(FX_TOP, FX_ONE, FX_HALF, FX_ONE),
                    px(FX_TOP, FX_ONE, FX_HALF, FX_ONE), '1, '1, 8'd255));
    send_req(mk_req(OP_FACTOR, px(FX_HALF, FX_HALF, FX_HALF, FX_ONE),
                    px(FX_HALF, FX_HALF, FX_HALF, FX_ONE), '0, '0, 8'd255));
    send_req(mk_req(OP_FACTOR, px(20'd1, 20'd2, 20'd3, FX_NEAR_CLIP),
                    px(0, 0, 0, 0), '0, '0, 8'd0));
    send_req(mk_req(OP_FACTOR, px(FX_ONE, FX_ONE, FX_ONE, FX_ONE),
                    px(20'd9, 20'd9, 20'd9, FX_TOP), '0, '0, 8'd0));
    send_req(mk_req(OP_FACTOR, px(FX_HALF, 20'd1, FX_ONE, FX_HALF),
                    px(20'd100, 20'd200, 20'd300, FX_HALF), '0, '0, 8'd128));
    // coverage masks: disjoint, partial, source covering dest, empty ones, full
    send_req(mk_req(OP_MASK, px(FX_HALF, 20'd1000, 20'd2, FX_HALF),
                    px(20'd3000, FX_HALF, 20'd4, FX_HALF), 16'h00ff, 16'hff00, '0));
    send_req(mk_req(OP_MASK, px(FX_HALF, 20'd1000, 20'd2, FX_ONE),
                    px(20'd3000, FX_HALF, 20'd4, FX_HALF), 16'h0ff0, 16'h00ff, '0));
    send_req(mk_req(OP_MASK, px(FX_HALF, 20'd1000, 20'd2, FX_ONE),
                    px(20'd3000, FX_HALF, 20'd4, FX_HALF), 16'h00f0, 16'h0ff0, '0));
    send_req(mk_req(OP_MASK, px(FX_HALF, 20'd1000, 20'd2, FX_ONE),
                    px(20'd3000, FX_HALF, 20'd4, FX_HALF), 16'h0000, 16'h0000, '0));
    send_req(mk_req(OP_MASK, px(FX_HALF, 20'd1000, 20'd2, FX_ONE),
                    px(20'd3000, FX_HALF, 20'd4, FX_HALF), 16'h0000, 16'h1234, '0));
    send_req(mk_req(OP_MASK, px(FX_HALF, 20'd1000, 20'd2, FX_ONE),
                    px(20'd3000, FX_HALF, 20'd4, FX_HALF), 16'h8421, 16'h0000, '0));
    send_req(mk_req(OP_MASK, px(FX_ONE, FX_ONE, FX_ONE, FX_ONE),
                    px(FX_HALF, FX_HALF, FX_HALF, FX_HALF), 16'hffff, 16'hffff, '1));
    send_req(mk_req(OP_MASK, px(FX_ONE, 20'd77, FX_HALF, FX_ONE),
                    px(20'd11, FX_HALF, 20'd5, FX_HALF), 16'hffff, 16'h0001, '0));
    // partial overlap with source alpha above one, then disjoint overflow
    send_req(mk_req(OP_MASK, px(FX_ONE, FX_HALF, 20'd9, FX_ONE),
                    px(20'd11, FX_HALF, 20'd5, FX_TOP), 16'hf0f0, 16'h0ff0, '0));
    send_req(mk_req(OP_MASK, px(FX_TOP, FX_TOP, FX_ONE, FX_TOP),
                    px(FX_TOP, 20'd1, FX_TOP, FX_TOP), 16'h5555, 16'haaaa, '1));

    // random phases: no idling, sender idle, receiver stalling, both
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(82, 0, PHASE_ITEMS);
    run_phase(0, 82, PHASE_ITEMS);
    run_phase(38, 38, PHASE_ITEMS);
    // back-pressure: long receiver hold-off while the sender never pauses
    holdoff_go = 1'b1;
    run_phase(0, 0, PHASE_ITEMS);
    in_valid <= 1'b0;

    // drain: wait for every predicted pixel, then idle for DRAIN_CYCLES
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("masked_alpha_compositing_top regression: pass");
    else
      $display("masked_alpha_compositing_top regression: fail");
    $finish;
  end

endmodule

>>> masked_alpha_compositing_top.f
sv/mac_pkg.sv
sv/mac_setup.sv
sv/mac_blend.sv
sv/mac_div.sv
sv/masked_alpha_compositing_top.sv
test/masked_alpha_compositing_checker.sv
test/tb_masked_alpha_compositing_top.sv
